@@ rtl/core/zsp_pkg.sv @@
// Shared constants, codes and divider handshake types for the z-buffer polygon fill core.
// Used by every module in rtl/core but zsp_ram; depends on nothing else.
package zsp_pkg;

  // Screen and polygon limits.
  localparam int SCREEN_W    = 1024;
  localparam int SCREEN_H    = 1024;
  localparam int MAX_CORNERS = 8;
  localparam int MIN_CORNERS = 3;

  // Field widths.
  localparam int ACT_W    = 2;
  localparam int COORD_W  = 10;
  localparam int Z_W      = 24;
  localparam int FACE_W   = 4;
  localparam int DEPTH_W  = 32;
  localparam int CD_W     = COORD_W + 1;
  localparam int ZD_W     = Z_W + 1;
  localparam int CORNER_W = 2 * COORD_W + Z_W;

  // Pixel store.
  localparam int PIX_COUNT = SCREEN_W * SCREEN_H;
  localparam int PIX_AW    = $clog2(PIX_COUNT);
  localparam int PIX_W     = FACE_W + DEPTH_W;

  // Corner list and crossing list.
  localparam int CNT_W     = $clog2(MAX_CORNERS + 1);
  localparam int CA_W      = $clog2(MAX_CORNERS);
  localparam int MAX_CROSS = 2 * MAX_CORNERS;
  localparam int CCNT_W    = $clog2(MAX_CROSS + 1);

  // Shared multiplier and divider.
  localparam int MUL_A_W = ZD_W;
  localparam int MUL_B_W = ZD_W + CD_W;
  localparam int PROD_W  = 48;
  localparam int NUM_W   = PROD_W;
  localparam int DEN_W   = 2 * CD_W + 1;
  localparam int QUO_W   = NUM_W + 1;
  localparam int DSTEP_W = $clog2(NUM_W + 1);

  // Pixel reset values.
  localparam logic [FACE_W-1:0]  NO_FACE   = '1;
  localparam logic [DEPTH_W-1:0] DEPTH_MIN = {1'b1, {(DEPTH_W-1){1'b0}}};
  localparam logic [DEPTH_W-1:0] DEPTH_MAX = {1'b0, {(DEPTH_W-1){1'b1}}};

  // Action codes.
  localparam logic [ACT_W-1:0] ACT_CLEAR = 2'd0;
  localparam logic [ACT_W-1:0] ACT_LOAD  = 2'd1;
  localparam logic [ACT_W-1:0] ACT_READ  = 2'd2;

  typedef struct packed {
    logic                    start;
    logic signed [NUM_W-1:0] num;
    logic signed [DEN_W-1:0] den;
  } div_req_t;

  typedef struct packed {
    logic                    done;
    logic signed [QUO_W-1:0] quot;
    logic                    rem_nz;
    logic                    neg;
  } div_res_t;

endpackage

@@ rtl/core/zsp_ram.sv @@
// Generic single-port-write, single-port-read RAM with a registered read.
// Stand-alone; no package needed.
module zsp_ram #(
  parameter int W     = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] wa,
  input  logic [W-1:0]             wd,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] ra,
  output logic [W-1:0]             rd
);

  logic [W-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rd <= mem[ra];
    end
  end

endmodule

@@ rtl/core/zsp_mul.sv @@
// Shared signed multiplier with a registered product.
// Depends on zsp_pkg for operand and product widths.
module zsp_mul (
  input  logic                                clk,
  input  logic signed [zsp_pkg::MUL_A_W-1:0]  a,
  input  logic signed [zsp_pkg::MUL_B_W-1:0]  b,
  output logic signed [zsp_pkg::PROD_W-1:0]   p
);
  import zsp_pkg::*;

  logic signed [MUL_A_W+MUL_B_W-1:0] full;

  // All products the sequencer asks for fit in the kept low bits.
  assign full = a * b;

  always_ff @(posedge clk) begin
    p <= full[PROD_W-1:0];
  end

endmodule

@@ rtl/core/zsp_div.sv @@
// Iterative signed divider, one quotient bit per cycle, truncating toward zero.
// Depends on zsp_pkg for widths and the request and result structs.
module zsp_div (
  input  logic              clk,
  input  logic              rst,
  input  zsp_pkg::div_req_t req,
  output zsp_pkg::div_res_t res
);
  import zsp_pkg::*;

  logic               busy;
  logic               done;
  logic [DSTEP_W-1:0] step;
  logic [NUM_W-1:0]   qacc;
  logic [DEN_W-1:0]   rem;
  logic [DEN_W-1:0]   dmag;
  logic               neg;
  logic [DEN_W:0]     rem_sh;
  logic               take;

  // One restoring step on the magnitudes.
  always_comb begin
    rem_sh = {rem, qacc[NUM_W-1]};
    take   = rem_sh >= {1'b0, dmag};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        step <= DSTEP_W'(NUM_W);
        qacc <= req.num[NUM_W-1] ? NUM_W'(-req.num) : NUM_W'(req.num);
        dmag <= req.den[DEN_W-1] ? DEN_W'(-req.den) : DEN_W'(req.den);
        rem  <= '0;
        neg  <= req.num[NUM_W-1] ^ req.den[DEN_W-1];
      end else if (busy) begin
        rem  <= take ? DEN_W'(rem_sh - {1'b0, dmag}) : rem_sh[DEN_W-1:0];
        qacc <= {qacc[NUM_W-2:0], take};
        step <= step - 1'b1;
        if (step == DSTEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Apply the sign to the quotient magnitude.
  always_comb begin
    res.done   = done;
    res.quot   = neg ? -$signed({1'b0, qacc}) : $signed({1'b0, qacc});
    res.rem_nz = rem != '0;
    res.neg    = neg;
  end

endmodule

@@ rtl/core/zbuffer_scanline_polygon_fill_core.sv @@
// Top level of the z-buffer scanline polygon fill: sequencer, pixel and corner stores.
// Depends on zsp_pkg, zsp_ram, zsp_mul and zsp_div.
//
//   channel | direction | handshake           | payload
//   in      | to core   | in_valid, in_stall  | action, pos_x, pos_y, pos_z, face_id, last
//   out     | from core | out_valid, out_stall| pixel_face, pixel_depth, done_res
//
// Each input transfer gives exactly one output transfer. A clear sweeps the pixel RAM port,
// one pixel written a cycle. A fill reads each corner and sets up the plane, then per row
// walks every edge (a peak or trough adds a second crossing, and an edge that crosses the
// row waits on the 48-step shared divider) and every span, and per covered pixel waits on
// that divider again. After reset a clearing pass over all PIX_COUNT pixels runs with
// in_stall high. A finished result waits in the output register while the next transfer
// is taken; only a second finished result waits on out_stall.
module zbuffer_scanline_polygon_fill_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic [zsp_pkg::ACT_W-1:0]           action,
  input  logic [zsp_pkg::COORD_W-1:0]         pos_x,
  input  logic [zsp_pkg::COORD_W-1:0]         pos_y,
  input  logic signed [zsp_pkg::Z_W-1:0]      pos_z,
  input  logic [zsp_pkg::FACE_W-1:0]          face_id,
  input  logic                                last,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic [zsp_pkg::FACE_W-1:0]          pixel_face,
  output logic signed [zsp_pkg::DEPTH_W-1:0]  pixel_depth,
  output logic                                done_res
);
  import zsp_pkg::*;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_RD, S_RDW, S_SCAN,
    S_PA, S_PB, S_PC, S_PD, S_PE, S_PF, S_PG, S_PH, S_PI,
    S_ROW, S_ROWB, S_E0, S_E1, S_E2, S_E3, S_E4, S_EX, S_EM, S_ED,
    S_SPAN, S_PIX, S_PIX1, S_PIXD, S_DONE
  } state_t;

  state_t state;

  // Control registers.
  logic [PIX_AW-1:0]  clr_cnt;
  logic               clr_res;
  logic [CNT_W-1:0]   ncnt;
  logic [CNT_W-1:0]   nf;
  logic [FACE_W-1:0]  cur_face;
  logic [CNT_W-1:0]   ci;
  logic               rv;
  logic [CNT_W-1:0]   ri;
  logic [CA_W-1:0]    ei;
  logic [CCNT_W-1:0]  ccnt;

  // Datapath registers.
  logic [COORD_W-1:0]        x1, y1, ymin, ymax, yrow, xcur, xe;
  logic signed [Z_W-1:0]     z1;
  logic signed [CD_W-1:0]    dx21, dy21, dx31, dy31;
  logic signed [ZD_W-1:0]    dz21, dz31;
  logic signed [PROD_W-1:0]  t, kk, rowbase;
  logic signed [MUL_B_W-1:0] ca, cb;
  logic signed [DEN_W-1:0]   dd;
  logic [COORD_W-1:0]        yp, xa, ya, xb, yb;
  logic [COORD_W-1:0]        cr [MAX_CROSS];
  logic [COORD_W-1:0]        cr_ins [MAX_CROSS];
  logic                      gt [MAX_CROSS];
  logic [FACE_W-1:0]         res_face;
  logic signed [DEPTH_W-1:0] res_depth;
  logic                      res_done;

  // Unit and store connections.
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod;
  div_req_t                  div_req;
  div_res_t                  div_res;
  logic                      c_we, c_re;
  logic [CA_W-1:0]           c_ra;
  logic [CORNER_W-1:0]       c_rd;
  logic                      pix_we, pix_re;
  logic [PIX_AW-1:0]         pix_wa, pix_addr;
  logic [PIX_W-1:0]          pix_wd, rd_pix;

  // Derived values.
  logic                      accept;
  logic [CNT_W-1:0]          ncnt_inc;
  logic [COORD_W-1:0]        cx, cy;
  logic signed [Z_W-1:0]     cz;
  logic signed [CD_W-1:0]    cdx, cdy, pxd, pyd, e_dx, e_dy, e_dyr;
  logic signed [ZD_W-1:0]    cdz;
  logic signed [PROD_W-1:0]  dval;
  logic                      edge_last, extremum, crossing, pix_on;
  logic signed [QUO_W-1:0]   qf;
  logic [COORD_W-1:0]        x_cr;
  logic [QUO_W-DEPTH_W:0]    qtop;
  logic signed [DEPTH_W-1:0] dsat, rd_depth;
  logic                      ins_en;
  logic [COORD_W-1:0]        ins_v;
  state_t                    edge_nxt;

  assign in_stall = state != S_IDLE;
  assign accept   = in_valid && !in_stall;
  assign ncnt_inc = (ncnt < CNT_W'(MAX_CORNERS)) ? ncnt + 1'b1 : ncnt;

  // Corner word fields and differences against corner zero.
  always_comb begin
    cx    = c_rd[CORNER_W-1 -: COORD_W];
    cy    = c_rd[Z_W +: COORD_W];
    cz    = $signed(c_rd[Z_W-1:0]);
    cdx   = $signed({1'b0, cx}) - $signed({1'b0, x1});
    cdy   = $signed({1'b0, cy}) - $signed({1'b0, y1});
    cdz   = ZD_W'(cz) - ZD_W'(z1);
    pxd   = $signed({1'b0, xcur}) - $signed({1'b0, x1});
    pyd   = $signed({1'b0, yrow}) - $signed({1'b0, y1});
    e_dx  = $signed({1'b0, xb}) - $signed({1'b0, xa});
    e_dy  = $signed({1'b0, yb}) - $signed({1'b0, ya});
    e_dyr = $signed({1'b0, yrow}) - $signed({1'b0, ya});
    dval  = t - prod;
  end

  // Edge classification for the current row.
  always_comb begin
    edge_last = ei == CA_W'(nf - 1'b1);
    edge_nxt  = edge_last ? S_SPAN : S_E0;
    extremum  = (yb > ya && yp > ya) || (yb < ya && yp < ya);
    crossing  = (ya < yrow && yb > yrow) || (ya > yrow && yb < yrow);
    pix_on    = (32'(xcur) < SCREEN_W) && (32'(yrow) < SCREEN_H);
    pix_addr  = PIX_AW'(PIX_AW'(yrow) * PIX_AW'(SCREEN_W)) + PIX_AW'(xcur);
  end

  // Divider result: floor for crossings, saturation for depths.
  always_comb begin
    qf       = div_res.quot - QUO_W'(div_res.rem_nz && div_res.neg);
    x_cr     = xa + qf[COORD_W-1:0];
    qtop     = div_res.quot[QUO_W-1:DEPTH_W-1];
    if ((&qtop) || !(|qtop)) begin
      dsat = div_res.quot[DEPTH_W-1:0];
    end else begin
      dsat = div_res.quot[QUO_W-1] ? DEPTH_MIN : DEPTH_MAX;
    end
    rd_depth = $signed(rd_pix[DEPTH_W-1:0]);
  end

  // Operand selection for the shared multiplier.
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state)
      S_PA:    begin mul_a = MUL_A_W'(dz31); mul_b = MUL_B_W'(dy21); end
      S_PB:    begin mul_a = MUL_A_W'(dz21); mul_b = MUL_B_W'(dy31); end
      S_PC:    begin mul_a = MUL_A_W'(dz21); mul_b = MUL_B_W'(dx31); end
      S_PD:    begin mul_a = MUL_A_W'(dz31); mul_b = MUL_B_W'(dx21); end
      S_PE:    begin mul_a = MUL_A_W'(dx31); mul_b = MUL_B_W'(dy21); end
      S_PF:    begin mul_a = MUL_A_W'(dy31); mul_b = MUL_B_W'(dx21); end
      S_PH:    begin mul_a = MUL_A_W'(z1);   mul_b = MUL_B_W'(dd);   end
      S_ROW:   begin mul_a = MUL_A_W'(pyd);  mul_b = cb;             end
      S_E4:    begin mul_a = MUL_A_W'(e_dyr); mul_b = MUL_B_W'(e_dx); end
      S_PIX:   begin mul_a = MUL_A_W'(pxd);  mul_b = ca;             end
      default: begin mul_a = '0;             mul_b = '0;             end
    endcase
  end

  // Divider requests: edge crossings and pixel depths.
  always_comb begin
    div_req.start = (state == S_EM) || (state == S_PIX1);
    if (state == S_EM) begin
      div_req.num = prod;
      div_req.den = DEN_W'(e_dy);
    end else begin
      div_req.num = rowbase + prod;
      div_req.den = dd;
    end
  end

  // Corner store ports.
  always_comb begin
    c_we = accept && (action == ACT_LOAD) && (ncnt < CNT_W'(MAX_CORNERS));
    c_re = 1'b0;
    c_ra = '0;
    unique case (state)
      S_SCAN: begin
        c_re = ci < nf;
        c_ra = ci[CA_W-1:0];
      end
      S_E0: begin
        c_re = 1'b1;
        c_ra = (ei == '0) ? CA_W'(nf - 1'b1) : ei - 1'b1;
      end
      S_E1: begin
        c_re = 1'b1;
        c_ra = ei;
      end
      S_E2: begin
        c_re = 1'b1;
        c_ra = edge_last ? '0 : ei + 1'b1;
      end
      default: begin
        c_re = 1'b0;
        c_ra = '0;
      end
    endcase
  end

  // Pixel store ports: clearing sweep, fill update and reads.
  always_comb begin
    pix_re = ((state == S_RD) || (state == S_PIX)) && pix_on;
    if (state == S_CLR) begin
      pix_we = 1'b1;
      pix_wa = clr_cnt;
      pix_wd = {NO_FACE, DEPTH_MIN};
    end else begin
      pix_we = (state == S_PIXD) && div_res.done && (dsat > rd_depth);
      pix_wa = pix_addr;
      pix_wd = {cur_face, dsat};
    end
  end

  // Sorted insertion into the crossing list.
  always_comb begin
    ins_en = ((state == S_E4) && (ya == yrow)) || (state == S_EX) ||
             ((state == S_ED) && div_res.done);
    ins_v  = (state == S_ED) ? x_cr : xa;
    for (int j = 0; j < MAX_CROSS; j++) begin
      gt[j] = (CCNT_W'(j) >= ccnt) || (cr[j] > ins_v);
    end
    cr_ins[0] = gt[0] ? ins_v : cr[0];
    for (int j = 1; j < MAX_CROSS; j++) begin
      if (!gt[j]) begin
        cr_ins[j] = cr[j];
      end else if (!gt[j-1]) begin
        cr_ins[j] = ins_v;
      end else begin
        cr_ins[j] = cr[j-1];
      end
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_cnt  <= '0;
      clr_res  <= 1'b0;
      out_valid <= 1'b0;
      ncnt     <= '0;
      cur_face <= '0;
      ccnt     <= '0;
      rv       <= 1'b0;
      ci       <= '0;
      ei       <= '0;
    end else begin
      // A result taken here is replaced in S_DONE, so only drop it elsewhere.
      if (out_valid && !out_stall && (state != S_DONE)) begin
        out_valid <= 1'b0;
      end
      if (ins_en && (ccnt < CCNT_W'(MAX_CROSS))) begin
        cr   <= cr_ins;
        ccnt <= ccnt + 1'b1;
      end
      unique case (state)
        S_CLR: begin
          // The sweep counter wraps back to zero on the last pixel.
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == PIX_AW'(PIX_COUNT - 1)) begin
            if (clr_res) begin
              state <= S_DONE;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        S_IDLE: begin
          if (in_valid) begin
            xcur      <= pos_x;
            yrow      <= pos_y;
            res_face  <= '0;
            res_depth <= '0;
            unique case (action)
              ACT_CLEAR: begin
                res_done <= 1'b1;
                clr_res  <= 1'b1;
                state    <= S_CLR;
              end
              ACT_LOAD: begin
                res_done <= 1'b1;
                cur_face <= face_id;
                if (last) begin
                  nf   <= ncnt_inc;
                  ncnt <= '0;
                  ci   <= '0;
                  rv   <= 1'b0;
                  state <= (ncnt_inc >= CNT_W'(MIN_CORNERS)) ? S_SCAN : S_DONE;
                end else begin
                  ncnt  <= ncnt_inc;
                  state <= S_DONE;
                end
              end
              ACT_READ: begin
                res_done <= 1'b1;
                state    <= S_RD;
              end
              default: begin
                res_done <= 1'b0;
                state    <= S_DONE;
              end
            endcase
          end
        end
        S_RD: begin
          if (pix_on) begin
            state <= S_RDW;
          end else begin
            res_face  <= NO_FACE;
            res_depth <= DEPTH_MIN;
            state     <= S_DONE;
          end
        end
        S_RDW: begin
          res_face  <= rd_pix[PIX_W-1 -: FACE_W];
          res_depth <= rd_depth;
          state     <= S_DONE;
        end
        // Read every corner once: first three set up the plane, all set the row range.
        S_SCAN: begin
          if (ci < nf) begin
            ci <= ci + 1'b1;
          end
          rv <= ci < nf;
          ri <= ci;
          if (rv) begin
            if (ri == '0) begin
              x1   <= cx;
              y1   <= cy;
              z1   <= cz;
              ymin <= cy;
              ymax <= cy;
            end else begin
              if (cy < ymin) begin
                ymin <= cy;
              end
              if (cy > ymax) begin
                ymax <= cy;
              end
            end
            if (ri == CNT_W'(1)) begin
              dx21 <= cdx;
              dy21 <= cdy;
              dz21 <= cdz;
            end
            if (ri == CNT_W'(2)) begin
              dx31 <= cdx;
              dy31 <= cdy;
              dz31 <= cdz;
            end
            if (ri == nf - 1'b1) begin
              state <= S_PA;
            end
          end
        end
        // Plane coefficients, one product per cycle.
        S_PA: state <= S_PB;
        S_PB: begin
          t     <= prod;
          state <= S_PC;
        end
        S_PC: begin
          ca    <= MUL_B_W'(dval);
          state <= S_PD;
        end
        S_PD: begin
          t     <= prod;
          state <= S_PE;
        end
        S_PE: begin
          cb    <= MUL_B_W'(dval);
          state <= S_PF;
        end
        S_PF: begin
          t     <= prod;
          state <= S_PG;
        end
        S_PG: begin
          dd <= DEN_W'(dval);
          if (dval == '0) begin
            state <= S_DONE;
          end else begin
            state <= S_PH;
          end
        end
        S_PH: state <= S_PI;
        S_PI: begin
          kk    <= prod;
          yrow  <= ymin;
          state <= S_ROW;
        end
        // Row set-up.
        S_ROW: begin
          ccnt  <= '0;
          ei    <= '0;
          state <= S_ROWB;
        end
        S_ROWB: begin
          rowbase <= kk + prod;
          state   <= S_E0;
        end
        // Fetch previous, current and next corner of the edge.
        S_E0: state <= S_E1;
        S_E1: begin
          yp    <= cy;
          state <= S_E2;
        end
        S_E2: begin
          xa    <= cx;
          ya    <= cy;
          state <= S_E3;
        end
        S_E3: begin
          xb    <= cx;
          yb    <= cy;
          state <= S_E4;
        end
        S_E4: begin
          if (ya == yrow) begin
            if (extremum) begin
              state <= S_EX;
            end else begin
              ei    <= ei + 1'b1;
              state <= edge_nxt;
            end
          end else if (crossing) begin
            state <= S_EM;
          end else begin
            ei    <= ei + 1'b1;
            state <= edge_nxt;
          end
        end
        S_EX: begin
          ei    <= ei + 1'b1;
          state <= edge_nxt;
        end
        S_EM: state <= S_ED;
        S_ED: begin
          if (div_res.done) begin
            ei    <= ei + 1'b1;
            state <= edge_nxt;
          end
        end
        // Take the next pair of crossings off the head of the list.
        S_SPAN: begin
          if (ccnt >= CCNT_W'(2)) begin
            xcur <= cr[0];
            xe   <= cr[1];
            for (int j = 0; j < MAX_CROSS - 2; j++) begin
              cr[j] <= cr[j+2];
            end
            ccnt  <= ccnt - CCNT_W'(2);
            state <= S_PIX;
          end else if (yrow == ymax) begin
            state <= S_DONE;
          end else begin
            yrow  <= yrow + 1'b1;
            state <= S_ROW;
          end
        end
        // Per pixel: product, division, depth test.
        S_PIX: begin
          if (pix_on) begin
            state <= S_PIX1;
          end else if (xcur == xe) begin
            state <= S_SPAN;
          end else begin
            xcur <= xcur + 1'b1;
          end
        end
        S_PIX1: state <= S_PIXD;
        S_PIXD: begin
          if (div_res.done) begin
            if (xcur == xe) begin
              state <= S_SPAN;
            end else begin
              xcur  <= xcur + 1'b1;
              state <= S_PIX;
            end
          end
        end
        S_DONE: begin
          if (!out_valid || !out_stall) begin
            out_valid   <= 1'b1;
            pixel_face  <= res_face;
            pixel_depth <= res_depth;
            done_res    <= res_done;
            state       <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  zsp_mul u_mul (
    .clk (clk),
    .a   (mul_a),
    .b   (mul_b),
    .p   (prod)
  );

  zsp_div u_div (
    .clk (clk),
    .rst (rst),
    .req (div_req),
    .res (div_res)
  );

  zsp_ram #(
    .W     (CORNER_W),
    .DEPTH (MAX_CORNERS)
  ) u_corner_ram (
    .clk (clk),
    .we  (c_we),
    .wa  (ncnt[CA_W-1:0]),
    .wd  ({pos_x, pos_y, pos_z}),
    .re  (c_re),
    .ra  (c_ra),
    .rd  (c_rd)
  );

  zsp_ram #(
    .W     (PIX_W),
    .DEPTH (PIX_COUNT)
  ) u_pix_ram (
    .clk (clk),
    .we  (pix_we),
    .wa  (pix_wa),
    .wd  (pix_wd),
    .re  (pix_re),
    .ra  (pix_addr),
    .rd  (rd_pix)
  );

  // Once a transfer is taken the core is busy for at least the following cycle.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> in_stall) else $error("input taken twice in a row");

  // The crossing list never holds more than its capacity.
  a_cross_cap: assert property (@(posedge clk) disable iff (rst)
    ccnt <= CCNT_W'(MAX_CROSS)) else $error("crossing list overflow");

  // The corner count never passes the corner store depth.
  a_corner_cap: assert property (@(posedge clk) disable iff (rst)
    ncnt <= CNT_W'(MAX_CORNERS)) else $error("corner count overflow");

  // Spans come from the sorted list, so the walk never passes the span end.
  a_span_order: assert property (@(posedge clk) disable iff (rst)
    (state == S_PIX) |-> (xcur <= xe)) else $error("span walk past its end");

  // Fill writes happen only for a face that is not edge-on.
  a_fill_plane: assert property (@(posedge clk) disable iff (rst)
    (pix_we && (state != S_CLR)) |-> (dd != '0)) else $error("write from edge-on face");

endmodule

@@ bench/zsp_checker.sv @@
// Scoreboard for the z-buffer polygon fill core: predicts each result and compares it.
// Depends on zsp_pkg; watches both channels of the core from beside it.
`timescale 1ns / 100ps

module zsp_checker (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  input  logic                                in_stall,
  input  logic [zsp_pkg::ACT_W-1:0]           action,
  input  logic [zsp_pkg::COORD_W-1:0]         pos_x,
  input  logic [zsp_pkg::COORD_W-1:0]         pos_y,
  input  logic signed [zsp_pkg::Z_W-1:0]      pos_z,
  input  logic [zsp_pkg::FACE_W-1:0]          face_id,
  input  logic                                last,
  input  logic                                out_valid,
  input  logic                                out_stall,
  input  logic [zsp_pkg::FACE_W-1:0]          pixel_face,
  input  logic signed [zsp_pkg::DEPTH_W-1:0]  pixel_depth,
  input  logic                                done_res,
  output int                                  fail_count,
  output int                                  pending
);
  import zsp_pkg::*;

  typedef struct {
    logic [FACE_W-1:0]         face;
    logic signed [DEPTH_W-1:0] depth;
    logic                      done;
  } pixel_answer_t;

  pixel_answer_t answer_q[$];

  // Shadow copy of the pixel stores and the corner list.
  logic signed [DEPTH_W-1:0] depth_mem [0:PIX_COUNT-1];
  logic [FACE_W-1:0]         face_mem  [0:PIX_COUNT-1];
  longint                    cx [0:MAX_CORNERS-1];
  longint                    cy [0:MAX_CORNERS-1];
  longint                    cz [0:MAX_CORNERS-1];
  int                        corners_held;
  logic [FACE_W-1:0]         face_now;

  task automatic report(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    fail_count++;
  endtask

  task automatic wipe_pixels();
    for (int i = 0; i < PIX_COUNT; i++) begin
      depth_mem[i] = DEPTH_MIN;
      face_mem[i]  = NO_FACE;
    end
  endtask

  function automatic longint div_floor(input longint num, input longint den);
    longint q;
    if (den < 0) begin
      num = -num;
      den = -den;
    end
    q = num / den;
    if ((num % den) != 0 && num < 0) q = q - 1;
    return q;
  endfunction

  // Scanline fill of the held corners with the plane through the first three.
  task automatic fill_face();
    longint x1, y1, z1, dx21, dy21, dz21, dx31, dy31, dz31, den;
    longint ylo, yhi, yy, xx, t, d, v, dy, num;
    longint xs [0:MAX_CROSS-1];
    int n, cnt, i, j, b, p, idx;
    n = corners_held;
    if (n < MIN_CORNERS) return;
    x1 = cx[0]; y1 = cy[0]; z1 = cz[0];
    dx21 = cx[1] - x1; dy21 = cy[1] - y1; dz21 = cz[1] - z1;
    dx31 = cx[2] - x1; dy31 = cy[2] - y1; dz31 = cz[2] - z1;
    den = dy21 * dx31 - dx21 * dy31;
    if (den == 0) return;
    ylo = cy[0];
    yhi = cy[0];
    for (i = 1; i < n; i++) begin
      if (cy[i] < ylo) ylo = cy[i];
      if (cy[i] > yhi) yhi = cy[i];
    end
    for (yy = ylo; yy <= yhi; yy++) begin
      cnt = 0;
      // Gather crossings; a corner at a local peak or trough counts twice.
      for (i = 0; i < n; i++) begin
        b = (i + 1) % n;
        p = (i + n - 1) % n;
        if (cy[i] == yy) begin
          if (cnt < MAX_CROSS) begin xs[cnt] = cx[i]; cnt++; end
          if ((cy[b] - cy[i]) * (cy[p] - cy[i]) > 0 && cnt < MAX_CROSS) begin
            xs[cnt] = cx[i];
            cnt++;
          end
        end
        if ((cy[i] < yy && cy[b] > yy) || (cy[i] > yy && cy[b] < yy)) begin
          dy  = cy[b] - cy[i];
          num = cx[i] * dy + (yy - cy[i]) * (cx[b] - cx[i]);
          if (cnt < MAX_CROSS) begin xs[cnt] = div_floor(num, dy); cnt++; end
        end
      end
      for (i = 1; i < cnt; i++) begin
        v = xs[i];
        j = i;
        while (j > 0 && xs[j-1] > v) begin
          xs[j] = xs[j-1];
          j--;
        end
        xs[j] = v;
      end
      // Fill between pairs; a lone final crossing is dropped.
      for (i = 0; i + 1 < cnt; i += 2) begin
        for (xx = xs[i]; xx <= xs[i+1]; xx++) begin
          if (xx < 0 || xx >= SCREEN_W || yy < 0 || yy >= SCREEN_H) continue;
          t = (xx - x1) * dy21 * dz31 + dx31 * (yy - y1) * dz21
              - dy31 * dz21 * (xx - x1) - dz31 * dx21 * (yy - y1);
          d = (t + z1 * den) / den;
          if (d > 64'sd2147483647) d = 64'sd2147483647;
          if (d < -64'sd2147483648) d = -64'sd2147483648;
          idx = int'(yy) * SCREEN_W + int'(xx);
          if (d > longint'(depth_mem[idx])) begin
            depth_mem[idx] = d[DEPTH_W-1:0];
            face_mem[idx]  = face_now;
          end
        end
      end
    end
  endtask

  initial begin
    fail_count = 0;
    pending    = 0;
    corners_held = 0;
    face_now   = '0;
    wipe_pixels();
  end

  // Predict on each input transfer, compare on each output transfer.
  always @(posedge clk) begin
    pixel_answer_t want, got;
    int idx;
    if (rst) begin
      corners_held = 0;
      face_now = '0;
    end else begin
      if (in_valid && !in_stall) begin
        want.face  = '0;
        want.depth = '0;
        want.done  = 1'b1;
        case (action)
          ACT_CLEAR: wipe_pixels();
          ACT_LOAD: begin
            if (corners_held < MAX_CORNERS) begin
              cx[corners_held] = longint'(pos_x);
              cy[corners_held] = longint'(pos_y);
              cz[corners_held] = longint'(pos_z);
              corners_held++;
            end
            face_now = face_id;
            if (last) begin
              fill_face();
              corners_held = 0;
            end
          end
          ACT_READ: begin
            idx = int'(pos_y) * SCREEN_W + int'(pos_x);
            want.face  = face_mem[idx];
            want.depth = depth_mem[idx];
          end
          default: want.done = 1'b0;
        endcase
        answer_q.insert(answer_q.size(), want);
      end
      if (out_valid && !out_stall) begin
        got.face  = pixel_face;
        got.depth = pixel_depth;
        got.done  = done_res;
        if (answer_q.size() == 0) begin
          report("result transfer with nothing expected");
        end else begin
          want = answer_q.pop_front();
          if (got.face !== want.face)
            report($sformatf("pixel_face %0d, expected %0d", got.face, want.face));
          if (got.depth !== want.depth)
            report($sformatf("pixel_depth %0d, expected %0d", got.depth, want.depth));
          if (got.done !== want.done)
            report($sformatf("done_res %0b, expected %0b", got.done, want.done));
        end
      end
    end
    pending = answer_q.size();
  end

endmodule

@@ bench/testbench.sv @@
// Stimulus and verdict for the z-buffer polygon fill core.
// Depends on zsp_pkg, the core and zsp_checker, which does all the comparing.
`timescale 1ns / 100ps

module testbench;
  import zsp_pkg::*;

  localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;
  localparam int CYCLE_LIMIT = 30_000_000;

  logic                       clk;
  logic                       rst;
  logic                       in_valid;
  logic                       in_stall;
  logic [ACT_W-1:0]           action;
  logic [COORD_W-1:0]         pos_x;
  logic [COORD_W-1:0]         pos_y;
  logic signed [Z_W-1:0]      pos_z;
  logic [FACE_W-1:0]          face_id;
  logic                       last;
  logic                       out_valid;
  logic                       out_stall;
  logic [FACE_W-1:0]          pixel_face;
  logic signed [DEPTH_W-1:0]  pixel_depth;
  logic                       done_res;
  int                         fail_count;
  int                         pending;
  int                         cycles;
  int                         sent;
  logic                       gaps_on;
  int                         bx, by;

  zbuffer_scanline_polygon_fill_core dut (.*);

  zsp_checker u_checker (.*);

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  // Safety net against a hung core.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver side: stall in random bursts while gaps are allowed.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (gaps_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 16)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // One input transfer, with an occasional idle burst before it.
  task automatic send(input logic [ACT_W-1:0] a, input int x, input int y,
                      input int z, input int f, input logic l);
    if (gaps_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    action   <= a;
    pos_x    <= x[COORD_W-1:0];
    pos_y    <= y[COORD_W-1:0];
    pos_z    <= z[Z_W-1:0];
    face_id  <= f[FACE_W-1:0];
    last     <= l;
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
    sent++;
  endtask

  task automatic corner(input int x, input int y, input int z, input int f,
                        input logic l);
    send(ACT_LOAD, x, y, z, f, l);
  endtask

  task automatic read_pixel(input int x, input int y);
    send(ACT_READ, x, y, $urandom, $urandom, $urandom_range(0, 1));
  endtask

  initial begin
    int n, nr;
    rst = 1'b1;
    in_valid = 1'b0;
    action = ACT_CLEAR;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    face_id = '0;
    last = 1'b0;
    cycles = 0;
    sent = 0;
    gaps_on = 1'b1;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // Directed: clear, a face at the far screen corner with extreme depths and id 15.
    send(ACT_CLEAR, 0, 0, 0, 0, 1'b0);
    corner(1023, 1023, 8388607, 15, 1'b0);
    corner(1016, 1023, -8388608, 15, 1'b0);
    corner(1023, 1016, 0, 15, 1'b1);
    read_pixel(1023, 1023);
    read_pixel(1020, 1021);
    // Edge-on face and a face with too few corners.
    corner(5, 5, 100, 3, 1'b0);
    corner(6, 6, 200, 3, 1'b0);
    corner(7, 7, 300, 3, 1'b1);
    corner(0, 0, 50, 4, 1'b0);
    corner(3, 3, 60, 4, 1'b1);
    read_pixel(0, 0);
    // Concave star with nine corners: one dropped, peaks and troughs counted twice.
    corner(40, 30, 256, 7, 1'b0);
    corner(44, 37, -512, 7, 1'b0);
    corner(50, 36, 1024, 7, 1'b0);
    corner(45, 41, 0, 7, 1'b0);
    corner(49, 48, 300, 7, 1'b0);
    corner(40, 43, 700, 7, 1'b0);
    corner(32, 48, -100, 7, 1'b0);
    corner(35, 40, 20, 7, 1'b0);
    corner(30, 35, 9, 7, 1'b1);
    read_pixel(40, 40);
    send(ACT_SPARE, 1023, 1023, -1, 15, 1'b1);

    // Random faces followed by reads around them.
    while (sent < 130) begin
      if (sent > 110) gaps_on = 1'b0;
      n  = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 10) : $urandom_range(3, 5);
      bx = ($urandom_range(0, 9) == 0) ? 1011 * $urandom_range(0, 1) : $urandom_range(0, 1011);
      by = ($urandom_range(0, 9) == 0) ? 1011 * $urandom_range(0, 1) : $urandom_range(0, 1011);
      nr = $urandom_range(0, 15);
      for (int i = 0; i < n; i++) begin
        corner(bx + $urandom_range(0, 12), by + $urandom_range(0, 12),
               ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 4095) - 2048,
               nr, i == n - 1);
      end
      repeat ($urandom_range(1, 3)) begin
        if ($urandom_range(0, 4) == 0) read_pixel($urandom_range(0, 1023), $urandom_range(0, 1023));
        else read_pixel(bx + $urandom_range(0, 12), by + $urandom_range(0, 12));
      end
      if ($urandom_range(0, 19) == 0)
        send(ACT_SPARE, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

@@ files.f @@
rtl/core/zsp_pkg.sv
rtl/core/zsp_ram.sv
rtl/core/zsp_mul.sv
rtl/core/zsp_div.sv
rtl/core/zbuffer_scanline_polygon_fill_core.sv
bench/zsp_checker.sv
bench/testbench.sv
